// ===== src/mgle_pkg.sv =====
// mgle_pkg: shared types, constants and helper functions for the median gated lsb embedder
// no dependencies
`timescale 1ns / 1ps

package mgle_pkg;

  localparam int MAX_COLUMN_LENGTH_DEF = 1024;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_PER_PIXEL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_LENGTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT   = 2'd3;

  localparam logic [7:0]  THRESHOLD_RST      = 8'd5;
  localparam logic [2:0]  BITS_PER_PIXEL_RST = 3'd5;
  localparam logic [10:0] COLUMN_LENGTH_RST  = 11'd1024;
  localparam logic [15:0] COLUMN_COUNT_RST   = 16'd1024;

  localparam logic [15:0] MIN_GEOMETRY = 16'd3;
  localparam logic [15:0] WINDOW_EDGE  = 16'd2;

  // grey = floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
  localparam logic [20:0] GREY_RECIP = 21'd683;
  localparam int          GREY_SHIFT = 11;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] mid;
    logic [7:0] hi;
  } trio_t;

  typedef struct packed {
    logic [7:0] centre_red;
    logic [7:0] centre_grey;
    logic [6:0] chunk;
  } side_t;

  function automatic trio_t sort3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    logic [7:0] t;
    trio_t res;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    res.lo  = x;
    res.mid = y;
    res.hi  = z;
    return res;
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    trio_t s;
    s = sort3(a, b, c);
    return s.mid;
  endfunction

  function automatic logic [7:0] grey_of(input logic [9:0] sum);
    logic [20:0] prod;
    prod = 21'(sum) * GREY_RECIP;
    return prod[GREY_SHIFT+7:GREY_SHIFT];
  endfunction

endpackage

// ===== src/mgle_line_store.sv =====
// mgle_line_store: red store of the last two columns and grey store of the last column
// depends on mgle_pkg
`timescale 1ns / 1ps

module mgle_line_store #(
  parameter int MAX_LEN = mgle_pkg::MAX_COLUMN_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(MAX_LEN)-1:0] row,
  input  logic                       col_lsb,
  input  logic [7:0]                 red,
  input  logic [9:0]                 rgb_sum,
  output logic [7:0]                 left2,
  output logic [7:0]                 left1,
  output logic [7:0]                 grey_rd
);
  import mgle_pkg::*;

  localparam int ROW_W     = $clog2(MAX_LEN);
  localparam int RED_DEPTH = 2 << ROW_W;

  logic [7:0] red_mem  [RED_DEPTH];
  logic [7:0] grey_mem [MAX_LEN];

  logic [ROW_W:0]   addr_same;
  logic [ROW_W:0]   addr_other;
  logic             gw_valid;
  logic [ROW_W-1:0] gw_addr;
  logic [9:0]       gw_sum;

  assign addr_same  = {col_lsb, row};
  assign addr_other = {~col_lsb, row};

  // read-first: the red entry of this row is read and replaced in the same beat
  always_ff @(posedge clk) begin
    if (rd_en) begin
      left2               <= red_mem[addr_same];
      left1               <= red_mem[addr_other];
      red_mem[addr_same]  <= red;
      grey_rd             <= grey_mem[row];
    end
    if (gw_valid) begin
      grey_mem[gw_addr] <= grey_of(gw_sum);
    end
  end

  // the grey write is registered and lands in the cycle after the read; consecutive beats never share a row
  always_ff @(posedge clk) begin
    if (rst) begin
      gw_valid <= 1'b0;
    end else begin
      gw_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      gw_addr <= row;
      gw_sum  <= rgb_sum;
    end
  end

endmodule

// ===== src/mgle_median.sv =====
// mgle_median: three stage median of nine network with side data carried along
// depends on mgle_pkg
`timescale 1ns / 1ps

module mgle_median (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [8:0][7:0]       in_vals,
  input  mgle_pkg::side_t       in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_median,
  output mgle_pkg::side_t       out_side
);
  import mgle_pkg::*;

  logic  v2;
  logic  v3;
  logic  v4;
  logic  r2;
  logic  r3;
  logic  r4;
  trio_t t2 [3];
  side_t side2;
  logic [7:0] lo3;
  logic [7:0] md3;
  logic [7:0] hi3;
  side_t side3;
  logic [7:0] med4;
  side_t side4;
  trio_t sorted [3];

  assign r4       = !v4 || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign in_ready = r2;

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      sorted[g] = sort3(in_vals[3*g], in_vals[3*g+1], in_vals[3*g+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r2) begin
        v2 <= in_valid;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        v4 <= v3;
      end
    end
  end

  // sorted triples
  always_ff @(posedge clk) begin
    if (in_valid && r2) begin
      t2    <= sorted;
      side2 <= in_side;
    end
  end

  // max of lows, median of mids, min of highs
  always_ff @(posedge clk) begin
    if (v2 && r3) begin
      lo3   <= max3(t2[0].lo, t2[1].lo, t2[2].lo);
      md3   <= med3(t2[0].mid, t2[1].mid, t2[2].mid);
      hi3   <= min3(t2[0].hi, t2[1].hi, t2[2].hi);
      side3 <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && r4) begin
      med4  <= med3(lo3, md3, hi3);
      side4 <= side3;
    end
  end

  assign out_valid  = v4;
  assign out_median = med4;
  assign out_side   = side4;

endmodule

// ===== src/median_gated_lsb_embedder.sv =====
// median_gated_lsb_embedder: top level, config registers, scan position, window and result beat
// depends on mgle_pkg, mgle_line_store, mgle_median
// path: an input beat passes the store read stage, the median stages and the output register
// throughput: one pixel per cycle without back-pressure; red store read and write share a beat
// reset: synchronous, clears config to defaults, scan position and all beat valids
// stores hold no reset value and need no clearing pass; reads come from the current frame
`timescale 1ns / 1ps

module median_gated_lsb_embedder #(
  parameter int MAX_COLUMN_LENGTH = mgle_pkg::MAX_COLUMN_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,   // red, green, blue, message_chunk, pad
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // stego_value
  output logic                                m_tuser,   // chunk_used
  input  logic                                cfg_we,
  input  logic [mgle_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mgle_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mgle_pkg::*;

  localparam int ROW_W = $clog2(MAX_COLUMN_LENGTH);

  logic [7:0]  threshold;
  logic [2:0]  bits_per_pixel;
  logic [10:0] column_length;
  logic [15:0] column_count;

  logic [ROW_W-1:0] row_pos;
  logic [15:0]      col_pos;
  logic [15:0]      len_raw;
  logic [15:0]      len_eff;
  logic [16:0]      cnt_eff;
  logic [15:0]      row_inc;
  logic [16:0]      col_inc;
  logic             geom_wr;
  logic             in_acc;
  logic             emit;

  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [6:0] in_chunk;
  logic [9:0] rgb_sum;

  logic       s1_valid;
  logic       s1_emit;
  logic [7:0] s1_red;
  logic [6:0] s1_chunk;
  logic       s1_go;
  logic [7:0] left2;
  logic [7:0] left1;
  logic [7:0] grey_rd;
  logic [7:0] grey_delay;
  logic [7:0] win [6];

  logic           med_in_valid;
  logic           med_in_ready;
  logic [8:0][7:0] med_vals;
  side_t          med_side_in;
  logic           med_out_valid;
  logic           med_out_ready;
  logic [7:0]     med_value;
  side_t          med_side_out;

  logic       out_valid;
  logic [7:0] out_value;
  logic       out_used;
  logic [7:0] dev;
  logic       marked;
  logic [6:0] mask;
  logic [7:0] val;

  assign in_red   = s_tdata[7:0];
  assign in_green = s_tdata[15:8];
  assign in_blue  = s_tdata[23:16];
  assign in_chunk = s_tdata[30:24];
  assign rgb_sum  = 10'(in_red) + 10'(in_green) + 10'(in_blue);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= THRESHOLD_RST;
      bits_per_pixel <= BITS_PER_PIXEL_RST;
      column_length  <= COLUMN_LENGTH_RST;
      column_count   <= COLUMN_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:      threshold      <= cfg_data[7:0];
        CFG_BITS_PER_PIXEL: bits_per_pixel <= cfg_data[2:0];
        CFG_COLUMN_LENGTH:  column_length  <= cfg_data[10:0];
        CFG_COLUMN_COUNT:   column_count   <= cfg_data[15:0];
      endcase
    end
  end

  assign geom_wr = cfg_we && (cfg_index == CFG_COLUMN_LENGTH || cfg_index == CFG_COLUMN_COUNT);

  // scan position
  assign len_raw = 16'(column_length);
  always_comb begin
    if (len_raw < MIN_GEOMETRY) begin
      len_eff = MIN_GEOMETRY;
    end else if (len_raw > 16'(MAX_COLUMN_LENGTH)) begin
      len_eff = 16'(MAX_COLUMN_LENGTH);
    end else begin
      len_eff = len_raw;
    end
  end
  assign cnt_eff = (column_count < MIN_GEOMETRY) ? 17'(MIN_GEOMETRY) : 17'(column_count);
  assign row_inc = 16'(row_pos) + 16'd1;
  assign col_inc = 17'(col_pos) + 17'd1;
  assign emit    = (col_pos >= WINDOW_EDGE) && (16'(row_pos) >= WINDOW_EDGE);

  assign s1_go    = s1_valid && (!s1_emit || med_in_ready);
  assign s_tready = !s1_valid || s1_go;
  assign in_acc   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (geom_wr) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (in_acc) begin
      if (row_inc >= len_eff) begin
        row_pos <= '0;
        col_pos <= (col_inc >= cnt_eff) ? 16'd0 : col_inc[15:0];
      end else begin
        row_pos <= row_inc[ROW_W-1:0];
      end
    end
  end

  mgle_line_store #(
    .MAX_LEN (MAX_COLUMN_LENGTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .row     (row_pos),
    .col_lsb (col_pos[0]),
    .red     (in_red),
    .rgb_sum (rgb_sum),
    .left2   (left2),
    .left1   (left1),
    .grey_rd (grey_rd)
  );

  // beat waiting on store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit  <= emit;
      s1_red   <= in_red;
      s1_chunk <= in_chunk;
    end
  end

  // window of the two rows above, shifted once per beat in order
  always_ff @(posedge clk) begin
    if (s1_go) begin
      win[0]     <= win[3];
      win[1]     <= win[4];
      win[2]     <= win[5];
      win[3]     <= left2;
      win[4]     <= left1;
      win[5]     <= s1_red;
      grey_delay <= grey_rd;
    end
  end

  assign med_in_valid = s1_valid && s1_emit;
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      med_vals[i] = win[i];
    end
    med_vals[6] = left2;
    med_vals[7] = left1;
    med_vals[8] = s1_red;
  end
  assign med_side_in.centre_red  = win[4];
  assign med_side_in.centre_grey = grey_delay;
  assign med_side_in.chunk       = s1_chunk;

  mgle_median u_median (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (med_in_valid),
    .in_ready   (med_in_ready),
    .in_vals    (med_vals),
    .in_side    (med_side_in),
    .out_valid  (med_out_valid),
    .out_ready  (med_out_ready),
    .out_median (med_value),
    .out_side   (med_side_out)
  );

  // deviation test and embedding
  always_comb begin
    dev = (med_side_out.centre_red > med_value) ? med_side_out.centre_red - med_value
                                                : med_value - med_side_out.centre_red;
    marked = dev > threshold;
    mask   = 7'((8'd1 << bits_per_pixel) - 8'd1);
    if (marked) begin
      val = (med_side_out.centre_grey & ~{mask, 1'b1})
          | {med_side_out.chunk & mask, 1'b1};
    end else begin
      val = {med_side_out.centre_grey[7:1], 1'b0};
    end
  end

  assign med_out_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (med_out_ready) begin
      out_valid <= med_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (med_out_valid && med_out_ready) begin
      out_value <= val;
      out_used  <= marked;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_used;

`ifndef ASSERT_OFF
  a_geom_restart: assert property (@(posedge clk) disable iff (rst)
    geom_wr |=> (row_pos == '0) && (col_pos == 16'd0))
    else $error("scan position not cleared by geometry write");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    16'(row_pos) < len_eff)
    else $error("row position beyond column length");

  a_marker_lsb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == m_tuser))
    else $error("marker bit disagrees with chunk_used");
`endif

endmodule
